// ===== hdl/lmfbs_pkg.sv =====
// Shared types and codes for the LED matrix frame buffer with row scan.
`timescale 1ns / 1ps

package lmfbs_pkg;

  localparam int ROW_W  = 3;
  localparam int COL_W  = 3;
  localparam int PIX_W  = 8;
  localparam int WORD_W = 16;

  typedef enum logic [2:0] {
    ACT_CLEAR     = 3'd0,
    ACT_SET       = 3'd1,
    ACT_TOGGLE    = 3'd2,
    ACT_RD_PIXEL  = 3'd3,
    ACT_WR_ROW    = 3'd4,
    ACT_RD_ROW    = 3'd5,
    ACT_INVERT    = 3'd6,
    ACT_SCAN      = 3'd7
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [PIX_W-1:0]   row_value;
    logic               bounce;
  } req_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   read_value;
    logic [WORD_W-1:0]  scan_word;
    logic [ROW_W-1:0]   scan_row;
    logic               is_scan;
    logic               last;
  } rsp_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_SET,
    OP_TOGGLE,
    OP_RD_PIXEL,
    OP_WR_ROW,
    OP_RD_ROW,
    OP_INVERT,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic [ROW_W-1:0]   scan_row;
    logic               last;
  } dp_cmd_t;

  typedef struct packed {
    logic               out_free;
  } dp_status_t;

endpackage

// ===== hdl/led_matrix_frame_buffer_scan_top.sv =====
// LED matrix frame buffer with row-multiplex scan: top level.
//
// The req channel takes one action item per accepted cycle (valid high, stall
// low). Clear, set, toggle, write row and invert update the frame buffer and
// give no result. Read pixel and read row give one rsp item, registered, on
// the cycle after acceptance. A scan gives ROWS words, or 2*ROWS-2 words with
// bounce set and ROWS above two, one per cycle while rsp_stall does not hold
// the output; the final word of a scan and every read reply carry last.
// Non-scan items are accepted back to back, one per cycle, as long as the
// output register is free or being taken. While a scan runs, req_stall stays
// high until the last word is in the output register; the scan sequencer
// uses the single buffer read port. When rsp_stall is high the waiting item
// holds, the scan pauses, and req_stall is raised as the output register is
// full.
// Rows at or above ROWS ignore writes and read as zero.
// Synchronous reset clears the frame buffer, the sequencer and rsp_valid;
// no item is to be sent while rst is high, which the block does not enforce.
`timescale 1ns / 1ps

module led_matrix_frame_buffer_scan_top #(
  parameter int ROWS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  lmfbs_pkg::req_item_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output lmfbs_pkg::rsp_item_t rsp
);
  import lmfbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lmfbs_ctrl #(
    .ROWS (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .status    (status),
    .cmd       (cmd)
  );

  lmfbs_datapath #(
    .ROWS (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== hdl/lmfbs_datapath.sv =====
// Datapath: frame buffer registers, row read mux and the output item register.
`timescale 1ns / 1ps

module lmfbs_datapath #(
  parameter int ROWS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lmfbs_pkg::req_item_t req,
  input  lmfbs_pkg::dp_cmd_t   cmd,
  output lmfbs_pkg::dp_status_t status,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output lmfbs_pkg::rsp_item_t rsp
);
  import lmfbs_pkg::*;

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [PIX_W-1:0] frame_buffer [ROWS];
  logic [PIX_W-1:0] col_mask;
  logic [PIX_W-1:0] rd_data;
  logic [ROW_W-1:0] rd_addr;
  logic             row_ok;
  logic             rd_ok;
  logic [PIX_W-1:0] row_enable;
  logic             load;
  rsp_item_t        rsp_next;

  assign col_mask = PIX_W'(1) << req.col;
  assign row_ok   = {1'b0, req.row} < (ROW_W + 1)'(ROWS);

  // One read port serves both the read actions and the scan sequencer.
  assign rd_addr = (cmd.op == OP_EMIT) ? cmd.scan_row : req.row;
  assign rd_ok   = {1'b0, rd_addr} < (ROW_W + 1)'(ROWS);
  assign rd_data = rd_ok ? frame_buffer[rd_addr[RW-1:0]] : '0;

  assign row_enable = ~(PIX_W'(1) << cmd.scan_row);

  assign status.out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    rsp_next = '0;
    load     = 1'b0;
    case (cmd.op)
      OP_RD_PIXEL: begin
        load                = 1'b1;
        rsp_next.read_value = PIX_W'(|(rd_data & col_mask));
        rsp_next.last       = 1'b1;
      end
      OP_RD_ROW: begin
        load                = 1'b1;
        rsp_next.read_value = rd_data;
        rsp_next.last       = 1'b1;
      end
      OP_EMIT: begin
        load               = 1'b1;
        rsp_next.scan_word = {row_enable, rd_data};
        rsp_next.scan_row  = cmd.scan_row;
        rsp_next.is_scan   = 1'b1;
        rsp_next.last      = cmd.last;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        frame_buffer[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          if (row_ok) frame_buffer[req.row[RW-1:0]] <= frame_buffer[req.row[RW-1:0]] & ~col_mask;
        end
        OP_SET: begin
          if (row_ok) frame_buffer[req.row[RW-1:0]] <= frame_buffer[req.row[RW-1:0]] | col_mask;
        end
        OP_TOGGLE: begin
          if (row_ok) frame_buffer[req.row[RW-1:0]] <= frame_buffer[req.row[RW-1:0]] ^ col_mask;
        end
        OP_WR_ROW: begin
          if (row_ok) frame_buffer[req.row[RW-1:0]] <= req.row_value;
        end
        OP_INVERT: begin
          for (int i = 0; i < ROWS; i++) begin
            frame_buffer[i] <= ~frame_buffer[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== hdl/lmfbs_ctrl.sv =====
// Controller: accepts items, decodes actions and sequences the row scan.
`timescale 1ns / 1ps

module lmfbs_ctrl #(
  parameter int ROWS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  lmfbs_pkg::req_item_t  req,
  input  lmfbs_pkg::dp_status_t status,
  output lmfbs_pkg::dp_cmd_t    cmd
);
  import lmfbs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0] TURN_ROW = ROW_W'(ROWS - 2);

  state_t           state;
  logic [ROW_W-1:0] scan_row;
  logic             backward;
  logic             bounce;
  logic             accept;
  logic             emit;
  logic             fwd_end;
  logic             scan_done;

  assign req_stall = (state == ST_SCAN) || !status.out_free;
  assign accept    = req_valid && !req_stall;
  assign emit      = (state == ST_SCAN) && status.out_free;

  // The forward pass ends on the top row; the backward pass ends on row one.
  assign fwd_end   = !backward && (scan_row == LAST_ROW);
  assign scan_done = (fwd_end && !bounce) || (backward && (scan_row == ROW_W'(1)));

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.scan_row = scan_row;
    cmd.last     = scan_done;
    if (emit) begin
      cmd.op = OP_EMIT;
    end else if (accept) begin
      case (req.action)
        ACT_CLEAR:    cmd.op = OP_CLEAR;
        ACT_SET:      cmd.op = OP_SET;
        ACT_TOGGLE:   cmd.op = OP_TOGGLE;
        ACT_RD_PIXEL: cmd.op = OP_RD_PIXEL;
        ACT_WR_ROW:   cmd.op = OP_WR_ROW;
        ACT_RD_ROW:   cmd.op = OP_RD_ROW;
        ACT_INVERT:   cmd.op = OP_INVERT;
        default:      cmd.op = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_row <= '0;
      backward <= 1'b0;
      bounce   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (req.action == ACT_SCAN)) begin
            state    <= ST_SCAN;
            scan_row <= '0;
            backward <= 1'b0;
            bounce   <= req.bounce && (ROWS > 2);
          end
        end
        ST_SCAN: begin
          if (emit) begin
            if (scan_done) begin
              state <= ST_IDLE;
            end else if (fwd_end) begin
              backward <= 1'b1;
              scan_row <= TURN_ROW;
            end else if (backward) begin
              scan_row <= scan_row - ROW_W'(1);
            end else begin
              scan_row <= scan_row + ROW_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/tb_led_matrix_frame_buffer_scan_top.sv =====
// Self-checking testbench for the LED matrix frame buffer with row scan.
`timescale 1ns / 1ps

module tb_led_matrix_frame_buffer_scan_top;
  import lmfbs_pkg::*;

  localparam int NUM_ROWS    = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_GAP     = 40;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  // Shadow copy of the display memory and the results it implies.
  logic [PIX_W-1:0] shadow_fb [0:7];
  rsp_item_t        pending_rsp [$];

  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_target   = 0;
  int hold_done     = 0;
  int mismatch_count = 0;
  int items_sent    = 0;
  int scan_words    = 0;
  int read_replies  = 0;

  led_matrix_frame_buffer_scan_top #(.ROWS(NUM_ROWS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < 8; i++) shadow_fb[i] = '0;
  end

  // Works out the replies and scan words that one accepted item produces.
  task automatic predict_action(input req_item_t it);
    rsp_item_t        r;
    logic [PIX_W-1:0] mask;
    int               back;
    int               total;
    int               rr;
    mask = 8'd1 << it.col;
    r = '0;
    case (it.action)
      ACT_CLEAR:  if (it.row < NUM_ROWS) shadow_fb[it.row] = shadow_fb[it.row] & ~mask;
      ACT_SET:    if (it.row < NUM_ROWS) shadow_fb[it.row] = shadow_fb[it.row] | mask;
      ACT_TOGGLE: if (it.row < NUM_ROWS) shadow_fb[it.row] = shadow_fb[it.row] ^ mask;
      ACT_WR_ROW: if (it.row < NUM_ROWS) shadow_fb[it.row] = it.row_value;
      ACT_RD_PIXEL: begin
        r.read_value = (it.row < NUM_ROWS && (shadow_fb[it.row] & mask) != 0) ? 8'd1 : 8'd0;
        r.last = 1'b1;
        pending_rsp.push_back(r);
      end
      ACT_RD_ROW: begin
        r.read_value = (it.row < NUM_ROWS) ? shadow_fb[it.row] : 8'd0;
        r.last = 1'b1;
        pending_rsp.push_back(r);
      end
      ACT_INVERT: begin
        for (int k = 0; k < NUM_ROWS; k++) shadow_fb[k] = ~shadow_fb[k];
      end
      ACT_SCAN: begin
        back = (it.bounce && NUM_ROWS > 2) ? NUM_ROWS - 2 : 0;
        total = NUM_ROWS + back;
        for (int k = 0; k < total; k++) begin
          // Past the forward pass the row index walks back down to 1.
          rr = (k < NUM_ROWS) ? k : 2 * NUM_ROWS - 2 - k;
          r = '0;
          r.is_scan   = 1'b1;
          r.scan_row  = ROW_W'(rr);
          r.scan_word = {~(8'd1 << rr), shadow_fb[rr]};
          r.last      = (k == total - 1);
          pending_rsp.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input req_item_t it);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predict_action(it);
    items_sent++;
  endtask

  // Drops valid so nothing is taken twice, then waits for every expected result.
  task automatic wait_all_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  function automatic req_item_t make_item(input action_t a, input int row, input int col,
                                          input int value, input bit bounce);
    req_item_t it;
    it.action    = a;
    it.row       = ROW_W'(row);
    it.col       = COL_W'(col);
    it.row_value = PIX_W'(value);
    it.bounce    = bounce;
    return it;
  endfunction

  function automatic req_item_t random_item();
    req_item_t it;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 12)      it.action = ACT_CLEAR;
    else if (pick < 26) it.action = ACT_SET;
    else if (pick < 38) it.action = ACT_TOGGLE;
    else if (pick < 52) it.action = ACT_RD_PIXEL;
    else if (pick < 64) it.action = ACT_WR_ROW;
    else if (pick < 78) it.action = ACT_RD_ROW;
    else if (pick < 84) it.action = ACT_INVERT;
    else                it.action = ACT_SCAN;
    it.row       = ROW_W'($urandom_range(7));
    it.col       = COL_W'($urandom_range(7));
    it.row_value = PIX_W'($urandom_range(255));
    it.bounce    = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic cmp_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      mismatch_count++;
    end
  endtask

  task automatic check_rsp(input rsp_item_t got);
    rsp_item_t want;
    if (got.is_scan) scan_words++;
    else read_replies++;
    if (pending_rsp.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      mismatch_count++;
    end else begin
      want = pending_rsp.pop_front();
      cmp_field("read_value", 16'(want.read_value), 16'(got.read_value));
      cmp_field("scan_word",  want.scan_word,       got.scan_word);
      cmp_field("scan_row",   16'(want.scan_row),   16'(got.scan_row));
      cmp_field("is_scan",    16'(want.is_scan),    16'(got.is_scan));
      cmp_field("last",       16'(want.last),       16'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) check_rsp(rsp);
  end

  // Receiver: random stalls, or a solid hold-off while hold cycles remain.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_done < hold_target) begin
      rsp_stall <= 1'b1;
      hold_done <= hold_done + 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  task automatic test_pixel_actions();
    send_item(make_item(ACT_RD_PIXEL, 0, 0, 8'h00, 1'b0));
    send_item(make_item(ACT_SET,      0, 0, 8'hFF, 1'b1));
    send_item(make_item(ACT_SET,      7, 7, 8'h00, 1'b0));
    send_item(make_item(ACT_RD_PIXEL, 7, 7, 8'hFF, 1'b1));
    send_item(make_item(ACT_TOGGLE,   3, 4, 8'h5A, 1'b0));
    send_item(make_item(ACT_RD_PIXEL, 3, 4, 8'h00, 1'b0));
    send_item(make_item(ACT_TOGGLE,   3, 4, 8'hA5, 1'b1));
    send_item(make_item(ACT_RD_PIXEL, 3, 4, 8'h00, 1'b0));
    send_item(make_item(ACT_CLEAR,    7, 7, 8'hFF, 1'b1));
    send_item(make_item(ACT_RD_PIXEL, 7, 7, 8'h00, 1'b0));
    wait_all_results();
  endtask

  task automatic test_row_actions();
    send_item(make_item(ACT_WR_ROW, 5, 0, 8'hFF, 1'b0));
    send_item(make_item(ACT_RD_ROW, 5, 7, 8'h00, 1'b1));
    send_item(make_item(ACT_WR_ROW, 2, 3, 8'hA5, 1'b0));
    send_item(make_item(ACT_RD_ROW, 2, 0, 8'h00, 1'b0));
    send_item(make_item(ACT_WR_ROW, 7, 7, 8'h00, 1'b1));
    send_item(make_item(ACT_INVERT, 0, 0, 8'h00, 1'b0));
    send_item(make_item(ACT_RD_ROW, 7, 0, 8'h00, 1'b0));
    send_item(make_item(ACT_RD_ROW, 0, 0, 8'hFF, 1'b1));
    wait_all_results();
  endtask

  task automatic test_scan_modes();
    send_item(make_item(ACT_SCAN,     0, 0, 8'h00, 1'b0));
    send_item(make_item(ACT_SCAN,     7, 7, 8'hFF, 1'b1));
    send_item(make_item(ACT_WR_ROW,   0, 0, 8'h80, 1'b0));
    send_item(make_item(ACT_RD_PIXEL, 0, 7, 8'h00, 1'b0));
    send_item(make_item(ACT_SCAN,     3, 2, 8'h11, 1'b1));
    wait_all_results();
  endtask

  task automatic test_random_traffic(input int sidle, input int ridle, input int count);
    send_idle_pct = sidle;
    rcv_stall_pct = ridle;
    repeat (count) send_item(random_item());
    wait_all_results();
  endtask

  // A long receiver hold-off while items keep coming fills the output and stalls input.
  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_target = hold_done + 300;
    repeat (30) send_item(random_item());
    wait_all_results();
  endtask

  // Random items, each sent only after the previous results have all come back.
  task automatic test_drain_pause();
    send_idle_pct = 29;
    rcv_stall_pct = 29;
    repeat (10) begin
      send_item(random_item());
      wait_all_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pixel_actions();
    test_row_actions();
    test_scan_modes();
    test_random_traffic(0, 0, 70);
    test_random_traffic(64, 0, 70);
    test_random_traffic(0, 64, 70);
    test_random_traffic(29, 29, 70);
    test_backpressure_fill();
    test_drain_pause();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $display("%0t: %0d results still expected, actual none", $time, pending_rsp.size());
      mismatch_count++;
    end
    $display("Sent %0d items over pixel, row, invert and scan actions under four idle mixes.",
             items_sent);
    $display("Checked %0d scan words and %0d read replies, including a long output hold-off.",
             scan_words, read_replies);
    if (mismatch_count == 0) begin
      $display("[led_matrix_frame_buffer_scan_top] OK");
    end else begin
      $display("[led_matrix_frame_buffer_scan_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", pending_rsp.size());
    $display("[led_matrix_frame_buffer_scan_top] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lmfbs_pkg.sv
hdl/lmfbs_datapath.sv
hdl/lmfbs_ctrl.sv
hdl/led_matrix_frame_buffer_scan_top.sv
sim/tb_led_matrix_frame_buffer_scan_top.sv
